>>> hw/rtl/masked_3x3_box_min_max_filter_core_assert.svh
// Assertion macros shared by the filter core RTL.
`ifndef MASKED_3X3_BOX_MIN_MAX_FILTER_CORE_ASSERT_SVH
`define MASKED_3X3_BOX_MIN_MAX_FILTER_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define MBMF_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define MBMF_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define MBMF_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define MBMF_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

>>> hw/rtl/mbmf_pkg.sv
// Types and constants of the masked 3x3 box / min / max filter.
`timescale 1ns / 1ps
package mbmf_pkg;

	localparam int CH_W         = 8;
	localparam int CFG_INDEX_W  = 3;
	localparam int CFG_DATA_W   = 11;
	localparam int DIM_MIN      = 3;
	localparam int WIDTH_RESET  = 640;
	localparam int HEIGHT_RESET = 480;

	// result buffer behind the pipeline
	localparam int FIFO_DEPTH = 8;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
	localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

	// sum of nine 8-bit values, and x/9 == (x * 7282) >> 16 for x < 32768
	localparam int SUM_W      = 12;
	localparam int DIV9_MUL   = 7282;
	localparam int DIV9_SHIFT = 16;

	typedef enum logic [1:0] {
		MODE_AVG  = 2'd0,
		MODE_MIN  = 2'd1,
		MODE_MAX  = 2'd2,
		MODE_PASS = 2'd3
	} filter_mode_t;

	localparam logic OP_FLUSH = 1'b1;

	localparam logic [CFG_INDEX_W-1:0] REG_FILTER_MODE  = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH  = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_MASK_ENABLE  = 3'd3;

	// pixel as held in the line stores and the window
	typedef struct packed {
		logic            mask;
		logic [CH_W-1:0] blue;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] red;
	} pixel_word_t;

	typedef struct packed {
		logic            opcode;
		logic [CH_W-1:0] in_red;
		logic [CH_W-1:0] in_green;
		logic [CH_W-1:0] in_blue;
		logic            mask_bit;
	} in_item_t;

	typedef struct packed {
		logic [CH_W-1:0] out_red;
		logic [CH_W-1:0] out_green;
		logic [CH_W-1:0] out_blue;
		logic            frame_last;
	} out_item_t;

endpackage

>>> hw/rtl/mbmf_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
`timescale 1ns / 1ps
module mbmf_ram #(
	parameter int WIDTH = 25,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		// read-before-write on an address collision
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

>>> hw/rtl/masked_3x3_box_min_max_filter_core.sv
// Masked 3x3 box / min / max filter core: line RAMs, window, filter pipe, result buffer.
`timescale 1ns / 1ps
`include "masked_3x3_box_min_max_filter_core_assert.svh"
// Throughput: one item per clock while pixel_stall is low; each line RAM does one read
//   and one write per cycle. The result of pixel p rides on the item frame_width + 1
//   later and reaches result through the RAM read, window, reduce and divide stages.
// Backpressure: an 8-entry result buffer; pixel_stall rises only when buffered plus
//   in-flight results fill it. Reset clears control and loads 640x480, average mode;
//   the line RAMs are not cleared and need no clearing pass.
module masked_3x3_box_min_max_filter_core #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// pixel channel
	input  logic                                pixel_valid,
	output logic                                pixel_stall,
	input  mbmf_pkg::in_item_t                  pixel,
	// result channel
	output logic                                result_valid,
	input  logic                                result_stall,
	output mbmf_pkg::out_item_t                 result,
	// configuration writes
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [mbmf_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [mbmf_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import mbmf_pkg::*;

	localparam int CW     = $clog2(MAX_WIDTH);      // column / RAM address
	localparam int WW     = $clog2(MAX_WIDTH + 1);  // frame width
	localparam int RW     = $clog2(MAX_HEIGHT + 2); // row, runs to height + 1 while draining
	localparam int PW     = $bits(pixel_word_t);
	localparam int PEND_W = CNT_W + 1;
	localparam int PROD_W = SUM_W + $clog2(DIV9_MUL + 1);
	localparam int W_RST  = (WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : WIDTH_RESET;
	localparam int H_RST  = (HEIGHT_RESET > MAX_HEIGHT) ? MAX_HEIGHT : HEIGHT_RESET;

	function automatic logic [CH_W-1:0] chan_of(pixel_word_t p, logic [1:0] k);
		logic [CH_W-1:0] v;
		case (k)
			2'd0:    v = p.red;
			2'd1:    v = p.green;
			default: v = p.blue;
		endcase
		return v;
	endfunction

	// ------------------------------------------------------------------
	// Configuration registers. Geometry is clamped on write.
	// ------------------------------------------------------------------
	filter_mode_t     mode_q;
	logic             mask_en_q;
	logic [WW-1:0]    w_q;
	logic [RW-1:0]    h_q;
	logic             cfg_we;
	logic             geom_we;
	logic [WW-1:0]    w_new;
	logic [RW-1:0]    h_new;

	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid & cfg_ready;
	assign geom_we   = cfg_we & ((cfg_index == REG_FRAME_WIDTH) ||
		(cfg_index == REG_FRAME_HEIGHT));

	always_comb begin
		if (int'(cfg_data) < DIM_MIN) begin
			w_new = WW'(DIM_MIN);
		end else if (int'(cfg_data) > MAX_WIDTH) begin
			w_new = WW'(MAX_WIDTH);
		end else begin
			w_new = WW'(cfg_data);
		end
		if (int'(cfg_data) < DIM_MIN) begin
			h_new = RW'(DIM_MIN);
		end else if (int'(cfg_data) > MAX_HEIGHT) begin
			h_new = RW'(MAX_HEIGHT);
		end else begin
			h_new = RW'(cfg_data);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= MODE_AVG;
			mask_en_q <= 1'b0;
			w_q       <= WW'(W_RST);
			h_q       <= RW'(H_RST);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_FILTER_MODE:  mode_q    <= filter_mode_t'(cfg_data[1:0]);
				REG_FRAME_WIDTH:  w_q       <= w_new;
				REG_FRAME_HEIGHT: h_q       <= h_new;
				REG_MASK_ENABLE:  mask_en_q <= cfg_data[0];
				default:          ; // unmapped index: ignored
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Stage 0: position tracking and line RAM read.
	// (c_q, r_q) is where the next item lands. Rows at or past the height
	// are the drain phase: any item acts as a flush and pushes zeros.
	// The window centre trails the input by one row and one column.
	// ------------------------------------------------------------------
	logic [CW-1:0]    c_q;
	logic [RW-1:0]    r_q;
	logic             pix_xfer;
	logic             draining;
	logic             proc;
	logic             col0;
	logic             col_wrap;
	logic             emit0;
	logic             border0;
	logic             last0;
	pixel_word_t      px0;

	assign pix_xfer = pixel_valid & ~pixel_stall;
	assign draining = (r_q >= h_q);
	// a flush before the frame is complete is dropped without effect
	assign proc     = pix_xfer & ~((pixel.opcode == OP_FLUSH) & ~draining);
	assign col0     = (c_q == '0);
	assign col_wrap = (c_q == CW'(w_q - WW'(1)));
	// column 0 closes the previous row: centre is at its right edge
	assign emit0    = col0 ? (r_q >= RW'(2)) : (r_q != '0);
	assign border0  = col0 | (c_q == CW'(1)) | (r_q == RW'(1)) | draining;
	assign last0    = col0 & (r_q > h_q);

	always_comb begin
		if (draining) begin
			px0 = '0;
		end else begin
			px0.mask  = pixel.mask_bit;
			px0.blue  = pixel.in_blue;
			px0.green = pixel.in_green;
			px0.red   = pixel.in_red;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c_q <= '0;
			r_q <= '0;
		end else if (geom_we) begin
			c_q <= '0;
			r_q <= '0;
		end else if (proc) begin
			if (last0) begin
				c_q <= '0;
				r_q <= '0;
			end else if (col_wrap) begin
				c_q <= '0;
				r_q <= r_q + RW'(1);
			end else begin
				c_q <= c_q + CW'(1);
			end
		end
	end

	// ------------------------------------------------------------------
	// Stage 1: RAM data back, read-modify-write of the line stores and the
	// window shift. Upper takes the old middle entry, middle takes the new
	// pixel. The only same-address back-to-back case is the wrap to column
	// zero after the last result; the written data is forwarded then.
	// ------------------------------------------------------------------
	logic             valid_s1;
	logic             fwd_s1;
	pixel_word_t      px_s1;
	logic [CW-1:0]    addr_s1;
	logic             emit_s1;
	logic             border_s1;
	logic             last_s1;
	pixel_word_t      wr_up_q;
	pixel_word_t      wr_mid_q;
	logic [PW-1:0]    up_rdata;
	logic [PW-1:0]    mid_rdata;
	pixel_word_t      up_eff;
	pixel_word_t      mid_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			fwd_s1   <= 1'b0;
		end else begin
			valid_s1 <= proc;
			fwd_s1   <= proc & valid_s1 & (c_q == addr_s1);
		end
	end

	always_ff @(posedge clk) begin
		if (proc) begin
			px_s1     <= px0;
			addr_s1   <= c_q;
			emit_s1   <= emit0;
			border_s1 <= border0;
			last_s1   <= last0;
		end
		if (valid_s1) begin
			wr_up_q  <= mid_eff;
			wr_mid_q <= px_s1;
		end
	end

	assign up_eff  = fwd_s1 ? wr_up_q  : pixel_word_t'(up_rdata);
	assign mid_eff = fwd_s1 ? wr_mid_q : pixel_word_t'(mid_rdata);

	mbmf_ram #(
		.WIDTH (PW),
		.DEPTH (MAX_WIDTH)
	) u_upper_ram (
		.clk     (clk),
		.wr_en   (valid_s1),
		.wr_addr (addr_s1),
		.wr_data (mid_eff),
		.rd_en   (proc),
		.rd_addr (c_q),
		.rd_data (up_rdata)
	);

	mbmf_ram #(
		.WIDTH (PW),
		.DEPTH (MAX_WIDTH)
	) u_middle_ram (
		.clk     (clk),
		.wr_en   (valid_s1),
		.wr_addr (addr_s1),
		.wr_data (px_s1),
		.rd_en   (proc),
		.rd_addr (c_q),
		.rd_data (mid_rdata)
	);

	// window: row 0 upper line, row 2 newest line; column 2 newest column
	pixel_word_t win_q [3][3];

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			for (int i = 0; i < 3; i++) begin
				win_q[i][0] <= win_q[i][1];
				win_q[i][1] <= win_q[i][2];
			end
			win_q[0][2] <= up_eff;
			win_q[1][2] <= mid_eff;
			win_q[2][2] <= px_s1;
		end
	end

	// ------------------------------------------------------------------
	// Stage 2: per-channel sum, minimum and maximum over the window, and
	// the copy decision (border, pass mode, or masked-off centre).
	// ------------------------------------------------------------------
	logic             valid_s2;
	logic             border_s2;
	logic             last_s2;
	logic [SUM_W-1:0] sum2 [3];
	logic [CH_W-1:0]  min2 [3];
	logic [CH_W-1:0]  max2 [3];
	logic             copy2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1 & emit_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			border_s2 <= border_s1;
			last_s2   <= last_s1;
		end
	end

	always_comb begin
		logic [CH_W-1:0] v;
		for (int k = 0; k < 3; k++) begin
			sum2[k] = '0;
			min2[k] = '1;
			max2[k] = '0;
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					v       = chan_of(win_q[i][j], 2'(k));
					sum2[k] = sum2[k] + SUM_W'(v);
					if (v < min2[k]) begin
						min2[k] = v;
					end
					if (v > max2[k]) begin
						max2[k] = v;
					end
				end
			end
		end
	end

	assign copy2 = border_s2 | (mode_q == MODE_PASS) | (mask_en_q & ~win_q[1][1].mask);

	// ------------------------------------------------------------------
	// Stage 3: divide by nine (reciprocal multiply) and final select.
	// ------------------------------------------------------------------
	logic             valid_s3;
	logic             copy_s3;
	logic             last_s3;
	pixel_word_t      centre_s3;
	logic [SUM_W-1:0] sum_s3 [3];
	logic [CH_W-1:0]  min_s3 [3];
	logic [CH_W-1:0]  max_s3 [3];
	logic [CH_W-1:0]  chv3 [3];
	out_item_t        res3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s2) begin
			copy_s3   <= copy2;
			last_s3   <= last_s2;
			centre_s3 <= win_q[1][1];
			for (int k = 0; k < 3; k++) begin
				sum_s3[k] <= sum2[k];
				min_s3[k] <= min2[k];
				max_s3[k] <= max2[k];
			end
		end
	end

	always_comb begin
		logic [PROD_W-1:0] prod;
		for (int k = 0; k < 3; k++) begin
			prod = PROD_W'(sum_s3[k]) * PROD_W'(DIV9_MUL);
			if (copy_s3) begin
				chv3[k] = chan_of(centre_s3, 2'(k));
			end else begin
				case (mode_q)
					MODE_AVG: chv3[k] = prod[DIV9_SHIFT +: CH_W];
					MODE_MIN: chv3[k] = min_s3[k];
					MODE_MAX: chv3[k] = max_s3[k];
					default:  chv3[k] = chan_of(centre_s3, 2'(k));
				endcase
			end
		end
		res3.out_red    = chv3[0];
		res3.out_green  = chv3[1];
		res3.out_blue   = chv3[2];
		res3.frame_last = last_s3;
	end

	// ------------------------------------------------------------------
	// Result buffer. Credits cover every result still in the pipe, so a
	// push never meets a full buffer.
	// ------------------------------------------------------------------
	out_item_t              fifo_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0]  wr_ptr_q;
	logic [FIFO_PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]       fifo_cnt_q;
	logic                   push;
	logic                   pop;
	logic [PEND_W-1:0]      pend;

	assign push = valid_s3;
	assign pop  = result_valid & ~result_stall;

	assign pend = PEND_W'(fifo_cnt_q) + PEND_W'(valid_s1 & emit_s1) +
		PEND_W'(valid_s2) + PEND_W'(valid_s3);
	assign pixel_stall = (pend >= PEND_W'(FIFO_DEPTH));

	assign result_valid = (fifo_cnt_q != '0);
	assign result       = fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= res3;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q   <= '0;
			rd_ptr_q   <= '0;
			fifo_cnt_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + FIFO_PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + FIFO_PTR_W'(1);
			end
			case ({push, pop})
				2'b10:   fifo_cnt_q <= fifo_cnt_q + CNT_W'(1);
				2'b01:   fifo_cnt_q <= fifo_cnt_q - CNT_W'(1);
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	`MBMF_ASSERT_IMP(a_no_overflow, clk, arst_n, valid_s3 && (fifo_cnt_q == CNT_W'(FIFO_DEPTH)), pop, "result buffer overflow")
	`MBMF_ASSERT_IMP(a_fwd_has_write, clk, arst_n, fwd_s1, valid_s1, "forward without write in stage 1")
	`MBMF_ASSERT_IMP(a_col_in_frame, clk, arst_n, 1'b1, int'(c_q) < int'(w_q), "column beyond frame width")
	`MBMF_ASSERT_IMP(a_row_in_range, clk, arst_n, 1'b1, int'(r_q) <= int'(h_q) + 1, "row beyond drain range")
	`MBMF_ASSERT_NXT(a_last_restart, clk, arst_n, proc && last0, (c_q == '0) && (r_q == '0), "frame did not restart after last")

endmodule

>>> bench/window_filter_checker.sv
// Checker for the masked 3x3 filter: predicts every result and compares it with the block.
`timescale 1ns / 1ps
module window_filter_checker
	import mbmf_pkg::*;
#(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   pixel_valid,
	input  logic                   pixel_stall,
	input  in_item_t               pixel,
	input  logic                   result_valid,
	input  logic                   result_stall,
	input  out_item_t              result,
	input  logic                   cfg_valid,
	input  logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	output int                     mismatches,
	output int                     outstanding
);

	localparam int REPORT_LIMIT = 40;

	// shadow registers
	filter_mode_t          mode;
	logic [CFG_DATA_W-1:0] width_reg;
	logic [CFG_DATA_W-1:0] height_reg;
	logic                  mask_en;

	// shadow of the line stores, the window and the stream position
	pixel_word_t upper_line [MAX_WIDTH];
	pixel_word_t middle_line [MAX_WIDTH];
	pixel_word_t win [9];
	int          col;
	int          row;

	out_item_t expected_pixels [$];
	int        fail_count;

	assign mismatches = fail_count;

	function automatic int clamp_dim(logic [CFG_DATA_W-1:0] v, int hi);
		if (v < DIM_MIN)
			return DIM_MIN;
		if (v > hi)
			return hi;
		return int'(v);
	endfunction

	function automatic int channel(pixel_word_t pw, int k);
		case (k)
			0: return int'(pw.red);
			1: return int'(pw.green);
			default: return int'(pw.blue);
		endcase
	endfunction

	function automatic logic [CH_W-1:0] reduce_channel(int k);
		int acc;
		int v;
		acc = (mode == MODE_MIN) ? 255 : 0;
		for (int i = 0; i < 9; i++) begin
			v = channel(win[i], k);
			case (mode)
				MODE_AVG: acc += v;
				MODE_MIN: if (v < acc) acc = v;
				default:  if (v > acc) acc = v;
			endcase
		end
		if (mode == MODE_AVG)
			acc = acc / 9;
		return CH_W'(acc);
	endfunction

	function automatic void apply_write(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		case (idx)
			REG_FILTER_MODE: mode = filter_mode_t'(data[1:0]);
			REG_FRAME_WIDTH: begin
				width_reg = data;
				col = 0;
				row = 0;
			end
			REG_FRAME_HEIGHT: begin
				height_reg = data;
				col = 0;
				row = 0;
			end
			REG_MASK_ENABLE: mask_en = data[0];
			default: ;
		endcase
	endfunction

	// one accepted input transfer: shift the window, queue the result it brings
	function automatic void advance_window(in_item_t it);
		int          w;
		int          h;
		int          r;
		int          c;
		int          cr;
		int          cc;
		bit          draining;
		bit          emit;
		bit          last;
		bit          keep;
		pixel_word_t px;
		pixel_word_t up;
		pixel_word_t mid;
		pixel_word_t centre;
		out_item_t   res;
		w = clamp_dim(width_reg, MAX_WIDTH);
		h = clamp_dim(height_reg, MAX_HEIGHT);
		r = row;
		c = col;
		draining = (r >= h);
		if (it.opcode == OP_FLUSH && !draining)
			return;
		if (draining)
			px = '0;
		else
			px = '{mask: it.mask_bit, blue: it.in_blue, green: it.in_green, red: it.in_red};
		c = c % MAX_WIDTH;
		up = upper_line[c];
		mid = middle_line[c];
		upper_line[c] = mid;
		middle_line[c] = px;
		for (int k = 0; k < 3; k++) begin
			win[k * 3] = win[k * 3 + 1];
			win[k * 3 + 1] = win[k * 3 + 2];
		end
		win[2] = up;
		win[5] = mid;
		win[8] = px;
		// window centre lags one row and one column behind the input
		if (c == 0) begin
			emit = (r >= 2);
			cr = r - 2;
			cc = w - 1;
		end else begin
			emit = (r >= 1);
			cr = r - 1;
			cc = c - 1;
		end
		c++;
		if (c >= w) begin
			c = 0;
			r++;
		end
		col = c;
		row = r;
		if (!emit)
			return;
		centre = win[4];
		last = (cr >= h - 1) && (cc >= w - 1);
		keep = (cr == 0) || (cr >= h - 1) || (cc == 0) || (cc >= w - 1) ||
			(mode == MODE_PASS) || (mask_en && !centre.mask);
		res.out_red    = keep ? centre.red   : reduce_channel(0);
		res.out_green  = keep ? centre.green : reduce_channel(1);
		res.out_blue   = keep ? centre.blue  : reduce_channel(2);
		res.frame_last = last;
		expected_pixels.push_back(res);
		if (last) begin
			col = 0;
			row = 0;
		end
	endfunction

	function automatic void compare_field(string name, logic [CH_W-1:0] want, logic [CH_W-1:0] got);
		if (got !== want) begin
			fail_count++;
			if (fail_count <= REPORT_LIMIT)
				$display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
		end
	endfunction

	function automatic void check_result(out_item_t got);
		out_item_t want;
		if (expected_pixels.size() == 0) begin
			fail_count++;
			if (fail_count <= REPORT_LIMIT)
				$display("%0t: result with nothing expected, actual r %0d g %0d b %0d last %0b",
					$time, got.out_red, got.out_green, got.out_blue, got.frame_last);
			return;
		end
		want = expected_pixels.pop_front();
		compare_field("out_red", want.out_red, got.out_red);
		compare_field("out_green", want.out_green, got.out_green);
		compare_field("out_blue", want.out_blue, got.out_blue);
		compare_field("frame_last", CH_W'(want.frame_last), CH_W'(got.frame_last));
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode = MODE_AVG;
			width_reg = CFG_DATA_W'(WIDTH_RESET);
			height_reg = CFG_DATA_W'(HEIGHT_RESET);
			mask_en = 1'b0;
			for (int i = 0; i < MAX_WIDTH; i++) begin
				upper_line[i] = '0;
				middle_line[i] = '0;
			end
			for (int i = 0; i < 9; i++)
				win[i] = '0;
			col = 0;
			row = 0;
			expected_pixels.delete();
			fail_count = 0;
			outstanding <= 0;
		end else begin
			if (cfg_valid && cfg_ready)
				apply_write(cfg_index, cfg_data);
			if (pixel_valid && !pixel_stall)
				advance_window(pixel);
			if (result_valid && !result_stall)
				check_result(result);
			outstanding <= expected_pixels.size();
		end
	end

endmodule

>>> bench/tb.sv
// Testbench top: drives pixel frames and register writes into the filter core, gives the verdict.
`timescale 1ns / 1ps
module tb;
	import mbmf_pkg::*;

	localparam int MAX_DIM        = 1024;
	localparam int ITEM_TARGET    = 1450;
	// covers the pipeline registers between a transfer and its result, plus the result buffer
	localparam int SETTLE_CYCLES  = 16;
	localparam int DRAIN_CYCLES   = 24;
	localparam int LONG_HOLD      = 300;
	localparam int WATCHDOG_LIMIT = 2000;

	// receiver stall styles
	typedef enum int {RX_FREE, RX_LIGHT, RX_HEAVY, RX_TOGGLE} rx_style_t;

	logic                   clk;
	logic                   arst_n       = 1'b0;
	logic                   pixel_valid  = 1'b0;
	logic                   pixel_stall;
	in_item_t               pixel        = '0;
	logic                   result_valid;
	logic                   result_stall = 1'b0;
	out_item_t              result;
	logic                   cfg_valid    = 1'b0;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index    = '0;
	logic [CFG_DATA_W-1:0]  cfg_data     = '0;

	int mismatches;
	int outstanding;

	// stimulus bookkeeping
	int frame_w;
	int frame_h;
	int burst_left   = 0;
	int counted_items = 0;
	bit hold_request = 1'b0;
	int idle_cycles  = 0;

	masked_3x3_box_min_max_filter_core #(
		.MAX_WIDTH  (MAX_DIM),
		.MAX_HEIGHT (MAX_DIM)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.pixel_valid  (pixel_valid),
		.pixel_stall  (pixel_stall),
		.pixel        (pixel),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	window_filter_checker #(
		.MAX_WIDTH  (MAX_DIM),
		.MAX_HEIGHT (MAX_DIM)
	) checker_i (
		.clk          (clk),
		.arst_n       (arst_n),
		.pixel_valid  (pixel_valid),
		.pixel_stall  (pixel_stall),
		.pixel        (pixel),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.mismatches   (mismatches),
		.outstanding  (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Watchdog: any transfer on any channel counts as progress. The limit sits well above
	// the long receiver hold and the settle pause around register writes.
	always @(posedge clk) begin
		if ((pixel_valid && !pixel_stall) || (result_valid && !result_stall) ||
				(cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// Receiver: phases of free flow, light or heavy random stall, toggling, and long random stalls.
	// Once the stimulus flags a long frame, it holds off once, long enough that the
	// result buffer fills and the block has to stall its pixel input.
	initial begin : receiver
		int        len;
		rx_style_t style;
		bit        held;
		held = 1'b0;
		forever begin
			if (hold_request && !held) begin
				held = 1'b1;
				result_stall <= 1'b1;
				repeat (LONG_HOLD) @(posedge clk);
			end else if ($urandom_range(0, 19) == 0) begin
				result_stall <= 1'b1;
				repeat ($urandom_range(60, 200)) @(posedge clk);
			end else begin
				len = $urandom_range(10, 150);
				style = rx_style_t'($urandom_range(RX_FREE, RX_TOGGLE));
				repeat (len) begin
					case (style)
						RX_FREE:  result_stall <= 1'b0;
						RX_LIGHT: result_stall <= ($urandom_range(0, 3) == 0);
						RX_HEAVY: result_stall <= ($urandom_range(0, 3) != 0);
						default:  result_stall <= ~result_stall;
					endcase
					@(posedge clk);
				end
			end
		end
	end

	function automatic int dim_used(int v);
		if (v < DIM_MIN)
			return DIM_MIN;
		if (v > MAX_DIM)
			return MAX_DIM;
		return v;
	endfunction

	function automatic in_item_t make_item(logic op, logic [CH_W-1:0] r, logic [CH_W-1:0] g,
			logic [CH_W-1:0] b, logic m);
		in_item_t it;
		it.opcode = op;
		it.in_red = r;
		it.in_green = g;
		it.in_blue = b;
		it.mask_bit = m;
		return it;
	endfunction

	function automatic in_item_t random_item(logic op);
		return make_item(op, CH_W'($urandom), CH_W'($urandom), CH_W'($urandom), 1'($urandom));
	endfunction

	// Sender: bursts of random length, random gaps between them. Valid stays high
	// across back-to-back transfers, only the payload moves on.
	task automatic offer(input in_item_t it);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap != 0) begin
				pixel_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 200) : $urandom_range(1, 24);
		end
		pixel <= it;
		pixel_valid <= 1'b1;
		do @(posedge clk); while (pixel_stall);
		burst_left--;
	endtask

	// Registers change only with the block idle: nothing offered, every expected result
	// delivered, then a pause for items still in the pipe that bring no result.
	task automatic wait_idle();
		pixel_valid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_index <= idx;
		cfg_data <= data;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// geometry write restarts the frame; frame_w/frame_h track the clamped sizes
	task automatic set_geometry(input int w_word, input int h_word);
		write_reg(REG_FRAME_WIDTH, CFG_DATA_W'(w_word));
		write_reg(REG_FRAME_HEIGHT, CFG_DATA_W'(h_word));
		frame_w = dim_used(w_word);
		frame_h = dim_used(h_word);
	endtask

	// only the low bits matter; the rest carry random junk
	task automatic set_mode(input filter_mode_t m);
		logic [CFG_DATA_W-1:0] word;
		word = CFG_DATA_W'($urandom);
		word[1:0] = m;
		write_reg(REG_FILTER_MODE, word);
	endtask

	task automatic set_mask(input logic en);
		logic [CFG_DATA_W-1:0] word;
		word = CFG_DATA_W'($urandom);
		word[0] = en;
		write_reg(REG_MASK_ENABLE, word);
	endtask

	// Sends pixel_total pixels. A full frame is followed by its drain items (flush or
	// pixel, both act as flush there); a short one is left broken for the next restart.
	// Stray flushes before the last pixel are ignored by the block and not counted.
	task automatic run_frame(input int pixel_total, input bit mode_swap, input bit counted);
		for (int k = 0; k < pixel_total; k++) begin
			if ($urandom_range(0, 19) == 0)
				offer(random_item(OP_FLUSH));
			if (mode_swap && k == pixel_total / 2) begin
				wait_idle();
				set_mode(filter_mode_t'($urandom_range(MODE_AVG, MODE_PASS)));
				if ($urandom_range(0, 1) == 0)
					set_mask(1'($urandom));
			end
			offer(random_item(1'b0));
			if (counted)
				counted_items++;
		end
		if (pixel_total == frame_w * frame_h) begin
			for (int k = 0; k <= frame_w; k++) begin
				offer(random_item(1'($urandom)));
				if (counted)
					counted_items++;
			end
		end
	endtask

	initial begin : stimulus
		int  frame_no;
		int  total;
		int  w_word;
		int  h_word;
		bit  broken;
		bit  restart;
		bit  do_geom;
		bit  do_mode;
		bit  do_mask;
		bit  do_bad;
		bit  big;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		wait_idle();

		// --- directed part ---
		// Low out-of-range sizes clamp to a 3x3 frame. Average of all-255 must stay 255.
		set_geometry(0, DIM_MIN - 1);
		set_mode(MODE_AVG);
		set_mask(1'b0);
		offer(make_item(OP_FLUSH, 8'hFF, 8'hFF, 8'hFF, 1'b1));
		for (int k = 0; k < 9; k++)
			offer(make_item(1'b0, 8'hFF, 8'hFF, 8'hFF, (k != 4)));
		// drain: pixels here are taken as flushes
		offer(make_item(1'b0, 8'h00, 8'h00, 8'h00, 1'b0));
		offer(make_item(OP_FLUSH, 8'h00, 8'h00, 8'h00, 1'b0));
		offer(make_item(1'b0, 8'h5A, 8'hA5, 8'hFF, 1'b1));
		offer(make_item(OP_FLUSH, 8'hFF, 8'hFF, 8'hFF, 1'b1));
		wait_idle();

		// minimum over a 0/255 checkerboard with masking on; stray index does nothing
		set_mode(MODE_MIN);
		set_mask(1'b1);
		write_reg(REG_MASK_ENABLE + 1, '1);
		for (int k = 0; k < 9; k++) begin
			if (k % 2 == 0)
				offer(make_item(1'b0, 8'hFF, 8'h00, 8'hFF, 1'b1));
			else
				offer(make_item(1'b0, 8'h00, 8'hFF, 8'h00, 1'b1));
		end
		for (int k = 0; k <= frame_w; k++)
			offer(make_item(OP_FLUSH, 8'h00, 8'h00, 8'h00, 1'b0));

		// --- random part ---
		frame_no = 0;
		restart = 1'b0;
		while (counted_items < ITEM_TARGET) begin
			big = (frame_no == 2) || (frame_no == 5);
			do_geom = restart || big || ($urandom_range(0, 2) == 0);
			do_mode = ($urandom_range(0, 1) == 0);
			do_mask = ($urandom_range(0, 2) == 0);
			do_bad = ($urandom_range(0, 9) == 0);
			if (do_geom || do_mode || do_mask || do_bad) begin
				wait_idle();
				if (do_geom) begin
					if (frame_no == 2) begin
						// widest frame, written above range so it clamps
						w_word = (1 << CFG_DATA_W) - 1;
						h_word = DIM_MIN;
					end else if (frame_no == 5) begin
						w_word = DIM_MIN;
						h_word = MAX_DIM;
					end else begin
						w_word = ($urandom_range(0, 7) == 0) ? $urandom_range(0, DIM_MIN - 1)
							: $urandom_range(DIM_MIN, 12);
						h_word = ($urandom_range(0, 7) == 0) ? $urandom_range(0, DIM_MIN - 1)
							: $urandom_range(DIM_MIN, 6);
					end
					set_geometry(w_word, h_word);
				end
				if (do_mode)
					set_mode(filter_mode_t'($urandom_range(MODE_AVG, MODE_PASS)));
				if (do_mask)
					set_mask(1'($urandom));
				if (do_bad)
					write_reg(CFG_INDEX_W'($urandom_range(REG_MASK_ENABLE + 1,
						(1 << CFG_INDEX_W) - 1)), CFG_DATA_W'($urandom));
			end
			if (frame_no == 2) begin
				// long frame: the receiver's long hold lands inside it
				hold_request = 1'b1;
				total = frame_w * frame_h;
				broken = 1'b0;
			end else if (frame_no == 5) begin
				// tallest frame, left after a few rows
				total = frame_w * 50;
				broken = 1'b1;
			end else begin
				broken = ($urandom_range(0, 7) == 0);
				total = broken ? $urandom_range(1, frame_w * frame_h - 1) : frame_w * frame_h;
			end
			run_frame(total, !broken && !big && ($urandom_range(0, 5) == 0), !big);
			restart = broken;
			frame_no++;
		end

		// all stimulus taken; wait for the tail of the results
		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

>>> files.f
+incdir+hw/rtl
hw/rtl/mbmf_pkg.sv
hw/rtl/mbmf_ram.sv
hw/rtl/masked_3x3_box_min_max_filter_core.sv
bench/window_filter_checker.sv
bench/tb.sv
